>>> rtl/bbp_pkg.sv
`timescale 1ns / 1ps
package bbp_pkg;

  // buffer geometry
  localparam int MAX_ENTRIES = 32;
  localparam int MAX_HISTORY = 8;
  localparam int ENT_W       = $clog2(MAX_ENTRIES);
  localparam int ROW_SIZE    = 1 << MAX_HISTORY;
  localparam int CNT_DEPTH   = MAX_ENTRIES * ROW_SIZE;
  localparam int CNT_AW      = $clog2(CNT_DEPTH);
  localparam int TAG_W       = 30;
  localparam int ADDR_W      = 32;

  // stream payload widths
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 104;

  // command codes
  localparam logic CMD_PREDICT = 1'b0;
  localparam logic CMD_UPDATE  = 1'b1;

  // share modes
  localparam logic [1:0] SHARE_HIST = 2'd0;
  localparam logic [1:0] SHARE_PC2  = 2'd1;
  localparam logic [1:0] SHARE_PC16 = 2'd2;

  // counter value after reset: weakly not taken
  localparam logic [1:0] CNT_WEAK_NT = 2'd1;

endpackage

>>> rtl/btb_two_level_branch_predictor.sv
`timescale 1ns / 1ps
// Branch target buffer with two-level direction prediction. After reset the block
// sweeps its whole counter memory (one counter a cycle) and its entry memories,
// and takes no item until that is done; configuration writes are accepted
// throughout. Each item then passes through one sequencer: entry read, counter
// index, then the counter read-modify-write and the result. A predict that misses
// on tag with per-entry history and per-entry tables adds a pass that resets the
// entry's row of counters. A result waits in an output register, so the next item
// is taken while it is still unread; the sequencer stalls only if a second result
// is ready before the first is taken.
module btb_two_level_branch_predictor (
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [71:0]  s_tdata,   // pc[31:0], resolved_target[63:32], resolved_taken[64]
  input  logic [0:0]   s_tuser,   // command[0]
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // predicted_taken[0], predicted_target[32:1],
                                  // mispredict_total[64:33], branch_total[96:65]
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int ENT_W  = bbp_pkg::ENT_W;
  localparam int CNT_AW = bbp_pkg::CNT_AW;
  localparam int HW     = bbp_pkg::MAX_HISTORY;
  localparam int TAG_W  = bbp_pkg::TAG_W;
  localparam int AW     = bbp_pkg::ADDR_W;

  // sequencer states
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SLOT  = 3'd2;
  localparam logic [2:0] ST_EXEC  = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;

  // register indexes
  localparam logic [2:0] REG_HIST_GLOBAL  = 3'd0;
  localparam logic [2:0] REG_TABLE_GLOBAL = 3'd1;
  localparam logic [2:0] REG_ENTRIES_LOG2 = 3'd2;
  localparam logic [2:0] REG_HIST_LEN     = 3'd3;
  localparam logic [2:0] REG_TAG_LEN      = 3'd4;
  localparam logic [2:0] REG_SHARE_MODE   = 3'd5;

  // configuration registers
  logic       history_global;
  logic       table_global;
  logic [2:0] entries_log2;
  logic [3:0] history_length;
  logic [4:0] tag_length;
  logic [1:0] share_mode;

  logic cfg_wr;
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      history_global <= 1'b1;
      table_global   <= 1'b1;
      entries_log2   <= 3'd5;
      history_length <= 4'd8;
      tag_length     <= 5'd30;
      share_mode     <= bbp_pkg::SHARE_HIST;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_HIST_GLOBAL:  history_global <= pwdata[0];
        REG_TABLE_GLOBAL: table_global   <= pwdata[0];
        REG_ENTRIES_LOG2: entries_log2   <= pwdata[2:0];
        REG_HIST_LEN:     history_length <= pwdata[3:0];
        REG_TAG_LEN:      tag_length     <= pwdata[4:0];
        REG_SHARE_MODE:   share_mode     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_HIST_GLOBAL:  prdata = {31'd0, history_global};
      REG_TABLE_GLOBAL: prdata = {31'd0, table_global};
      REG_ENTRIES_LOG2: prdata = {29'd0, entries_log2};
      REG_HIST_LEN:     prdata = {28'd0, history_length};
      REG_TAG_LEN:      prdata = {27'd0, tag_length};
      REG_SHARE_MODE:   prdata = {30'd0, share_mode};
      default:          prdata = 32'd0;
    endcase
  end

  // clamped configuration
  logic [2:0]       ent_eff;
  logic [3:0]       hl_eff;
  logic [4:0]       tl_eff;
  logic [ENT_W-1:0] ent_mask;
  logic [HW-1:0]    hmask;
  logic [TAG_W-1:0] tmask;

  always_comb begin
    ent_eff  = (entries_log2 > 3'd5) ? 3'd5 : entries_log2;
    hl_eff   = (history_length == 4'd0) ? 4'd1 :
               (history_length > 4'(HW)) ? 4'(HW) : history_length;
    tl_eff   = (tag_length > 5'd30) ? 5'd30 : tag_length;
    ent_mask = ENT_W'((6'd1 << ent_eff) - 6'd1);
    hmask    = HW'((9'd1 << hl_eff) - 9'd1);
    tmask    = TAG_W'((31'd1 << tl_eff) - 31'd1);
  end

  // sequencer and item registers
  logic [2:0]        state;
  logic [CNT_AW-1:0] clr_cnt;
  logic [HW-1:0]     walk_cnt;
  logic              cmd_q;
  logic [AW-1:0]     pc_q;
  logic [AW-1:0]     rtgt_q;
  logic              rtaken_q;
  logic [ENT_W-1:0]  idx_q;
  logic [CNT_AW-1:0] slot_q;
  logic [HW-1:0]     shared_history;
  logic              last_direction;
  logic [31:0]       mispredict_count;
  logic [31:0]       branch_count;

  logic             accept;
  logic [ENT_W-1:0] idx_in;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid & s_tready;
  assign idx_in   = s_tdata[ENT_W+1:2] & ent_mask;

  // memory read data
  logic [TAG_W-1:0] tag_rd;
  logic [AW-1:0]    tgt_rd;
  logic [HW-1:0]    eh_rd;
  logic [1:0]       cnt_rd;

  // counter index from history, optionally hashed with pc bits
  logic [HW-1:0]     hsel;
  logic [HW-1:0]     hx;
  logic [CNT_AW-1:0] slot_next;

  always_comb begin
    hsel = history_global ? shared_history : eh_rd;
    case (share_mode)
      bbp_pkg::SHARE_PC2:  hx = hsel ^ pc_q[HW+1:2];
      bbp_pkg::SHARE_PC16: hx = hsel ^ pc_q[HW+15:16];
      default:             hx = hsel;
    endcase
    if (table_global) begin
      slot_next = {{ENT_W{1'b0}}, hx & hmask};
    end else begin
      slot_next = {idx_q, hsel & hmask};
    end
  end

  // execute step
  logic             out_free;
  logic             tag_miss;
  logic             taken_o;
  logic [AW-1:0]    target_o;
  logic [1:0]       cnt_new;
  logic [HW-1:0]    hist_new;
  logic [TAG_W-1:0] tag_pc;
  logic             exec_go;

  assign out_free = ~m_tvalid | m_tready;
  assign exec_go  = (state == ST_EXEC) & out_free;
  assign tag_pc   = pc_q[AW-1:2] & tmask;
  assign tag_miss = (tag_rd != '0) && (tag_rd != tag_pc);
  assign taken_o  = (cmd_q == bbp_pkg::CMD_PREDICT) & cnt_rd[1] & ~tag_miss;
  assign target_o = taken_o ? tgt_rd : pc_q + 32'd4;
  assign hist_new = {hsel[HW-2:0], rtaken_q} & hmask;

  // saturating counter step
  always_comb begin
    cnt_new = cnt_rd;
    if (rtaken_q) begin
      if (cnt_rd != 2'd3) begin
        cnt_new = cnt_rd + 2'd1;
      end
    end else if (cnt_rd != 2'd0) begin
      cnt_new = cnt_rd - 2'd1;
    end
  end

  // memory write ports: clearing sweep, row reset, or the execute step
  logic              cnt_we;
  logic [CNT_AW-1:0] cnt_waddr;
  logic [1:0]        cnt_wdata;
  logic              ent_we;
  logic              eh_we;
  logic [ENT_W-1:0]  ent_waddr;
  logic [TAG_W-1:0]  tag_wdata;
  logic [AW-1:0]     tgt_wdata;
  logic [HW-1:0]     eh_wdata;

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = slot_q;
    cnt_wdata = cnt_new;
    ent_we    = 1'b0;
    eh_we     = 1'b0;
    ent_waddr = idx_q;
    tag_wdata = tag_pc;
    tgt_wdata = rtgt_q;
    eh_wdata  = hist_new;
    if (state == ST_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_cnt;
      cnt_wdata = bbp_pkg::CNT_WEAK_NT;
      ent_we    = 1'b1;
      eh_we     = 1'b1;
      ent_waddr = clr_cnt[ENT_W-1:0];
      tag_wdata = '0;
      tgt_wdata = '0;
      eh_wdata  = '0;
    end else if (state == ST_WALK) begin
      cnt_we    = 1'b1;
      cnt_waddr = {idx_q, walk_cnt};
      cnt_wdata = bbp_pkg::CNT_WEAK_NT;
    end else if (exec_go) begin
      if (cmd_q == bbp_pkg::CMD_UPDATE) begin
        cnt_we = 1'b1;
        ent_we = 1'b1;
        eh_we  = ~history_global;
      end else if (tag_miss && !history_global) begin
        eh_we    = 1'b1;
        eh_wdata = '0;
      end
    end
  end

  bbp_ram #(.WIDTH(TAG_W), .DEPTH(bbp_pkg::MAX_ENTRIES)) u_tag (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(tag_wdata),
    .re(accept), .raddr(idx_in), .rdata(tag_rd)
  );

  bbp_ram #(.WIDTH(AW), .DEPTH(bbp_pkg::MAX_ENTRIES)) u_target (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(tgt_wdata),
    .re(accept), .raddr(idx_in), .rdata(tgt_rd)
  );

  bbp_ram #(.WIDTH(HW), .DEPTH(bbp_pkg::MAX_ENTRIES)) u_hist (
    .clk(clk), .we(eh_we), .waddr(ent_waddr), .wdata(eh_wdata),
    .re(accept), .raddr(idx_in), .rdata(eh_rd)
  );

  bbp_ram #(.WIDTH(2), .DEPTH(bbp_pkg::CNT_DEPTH)) u_counter (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .re(state == ST_SLOT), .raddr(slot_next), .rdata(cnt_rd)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      walk_cnt <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (&clr_cnt) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_SLOT;
          end
        end
        ST_SLOT: state <= ST_EXEC;
        ST_EXEC: begin
          if (out_free) begin
            // a predict tag miss with per-entry history and tables resets the whole row
            if (cmd_q == bbp_pkg::CMD_PREDICT && tag_miss &&
                !history_global && !table_global) begin
              state    <= ST_WALK;
              walk_cnt <= '0;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_WALK: begin
          walk_cnt <= walk_cnt + 1'b1;
          if (&walk_cnt) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= s_tuser[0];
      pc_q     <= s_tdata[31:0];
      rtgt_q   <= s_tdata[63:32];
      rtaken_q <= s_tdata[64];
      idx_q    <= idx_in;
    end
    if (state == ST_SLOT) begin
      slot_q <= slot_next;
    end
  end

  // predictor state outside the memories
  always_ff @(posedge clk) begin
    if (rst) begin
      shared_history   <= '0;
      last_direction   <= 1'b0;
      mispredict_count <= '0;
      branch_count     <= '0;
    end else if (exec_go) begin
      if (cmd_q == bbp_pkg::CMD_PREDICT) begin
        branch_count   <= branch_count + 32'd1;
        last_direction <= taken_o;
      end else begin
        if (rtaken_q != last_direction) begin
          mispredict_count <= mispredict_count + 32'd1;
        end
        if (history_global) begin
          shared_history <= hist_new;
        end
      end
    end
  end

  // result register
  logic [31:0] br_out;
  logic [31:0] mis_out;
  assign br_out  = (cmd_q == bbp_pkg::CMD_PREDICT) ? branch_count + 32'd1 : branch_count;
  assign mis_out = (cmd_q == bbp_pkg::CMD_UPDATE && rtaken_q != last_direction) ?
                   mispredict_count + 32'd1 : mispredict_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      m_tdata <= {7'd0, br_out, mis_out,
                  (cmd_q == bbp_pkg::CMD_PREDICT) ? target_o : 32'd0, taken_o};
    end
  end

  // checks
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !s_tready) else $error("item taken during clearing sweep");

  a_branch_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (branch_count == $past(branch_count) ||
              branch_count == $past(branch_count) + 32'd1))
    else $error("branch count jumped");

  a_mispredict_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (mispredict_count == $past(mispredict_count) ||
              mispredict_count == $past(mispredict_count) + 32'd1))
    else $error("mispredict count jumped");

  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_EXEC) else $error("result without execute step");

endmodule

>>> rtl/bbp_ram.sv
`timescale 1ns / 1ps
module bbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
